// ===== src/pm0_pkg.sv =====
// Shared opcodes, fault codes and control type of the PM/0 execute block.
package pm0_pkg;

  // Opcodes.
  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_RTN = 5'd2;
  localparam logic [4:0] OP_LOD = 5'd3;
  localparam logic [4:0] OP_STO = 5'd4;
  localparam logic [4:0] OP_CAL = 5'd5;
  localparam logic [4:0] OP_INC = 5'd6;
  localparam logic [4:0] OP_JMP = 5'd7;
  localparam logic [4:0] OP_JPC = 5'd8;
  localparam logic [4:0] OP_OUT = 5'd9;
  localparam logic [4:0] OP_IN  = 5'd10;
  localparam logic [4:0] OP_HLT = 5'd11;
  localparam logic [4:0] OP_NEG = 5'd12;
  localparam logic [4:0] OP_ADD = 5'd13;
  localparam logic [4:0] OP_SUB = 5'd14;
  localparam logic [4:0] OP_MUL = 5'd15;
  localparam logic [4:0] OP_DIV = 5'd16;
  localparam logic [4:0] OP_ODD = 5'd17;
  localparam logic [4:0] OP_MOD = 5'd18;
  localparam logic [4:0] OP_EQL = 5'd19;
  localparam logic [4:0] OP_NEQ = 5'd20;
  localparam logic [4:0] OP_LSS = 5'd21;
  localparam logic [4:0] OP_LEQ = 5'd22;
  localparam logic [4:0] OP_GTR = 5'd23;
  localparam logic [4:0] OP_GEQ = 5'd24;

  // Fault codes.
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_DIV0  = 2'd1;
  localparam logic [1:0] FLT_STACK = 2'd2;

  // Control of the iterative multiply and divide unit.
  typedef struct packed {
    logic start;
    logic mul;
  } md_ctl_t;

endpackage

// ===== src/pm0_if.sv =====
// Valid/ready channel interfaces for instructions and results.
interface pm0_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         op;
  logic [2:0]         reg_sel;
  logic [2:0]         field_l;
  logic signed [31:0] field_m;
  logic signed [31:0] in_value;

  modport source (output valid, op, reg_sel, field_l, field_m, in_value, input ready);
  modport sink (input valid, op, reg_sel, field_l, field_m, in_value, output ready);
endinterface

interface pm0_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         next_pc;
  logic [5:0]         base_ptr;
  logic [5:0]         stack_ptr;
  logic signed [31:0] out_value;
  logic               out_valid;
  logic               halted;
  logic [1:0]         fault;

  modport source (output valid, next_pc, base_ptr, stack_ptr, out_value, out_valid,
                  halted, fault, input ready);
  modport sink (input valid, next_pc, base_ptr, stack_ptr, out_value, out_valid,
                halted, fault, output ready);
endinterface

// ===== src/pm0_stack_ram.sv =====
// Word stack memory with one write port and one registered read port.
module pm0_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write, and a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pm0_muldiv.sv =====
// Iterative unsigned shift-add multiplier and restoring divider, one bit a cycle.
module pm0_muldiv #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pm0_pkg::md_ctl_t       ctl,
  input  logic [W-1:0]           opa,
  input  logic [W-1:0]           opb,
  output logic                   done,
  output logic [W-1:0]           quot,
  output logic [W-1:0]           acc
);
  import pm0_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          mul_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [W:0]    acc_r;
  logic [W:0]    dtry;
  logic          dge;

  // One restoring division step.
  assign dtry = {acc_r[W-1:0], x_r[W-1]};
  assign dge  = (dtry >= {1'b0, y_r});

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: x shifts the multiplier or builds the quotient.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mul_r <= ctl.mul;
      x_r   <= opa;
      y_r   <= opb;
      acc_r <= '0;
    end else if (busy_r) begin
      if (mul_r) begin
        acc_r <= acc_r + (x_r[0] ? {1'b0, y_r} : '0);
        x_r   <= x_r >> 1;
        y_r   <= y_r << 1;
      end else begin
        acc_r <= dge ? (dtry - {1'b0, y_r}) : dtry;
        x_r   <= {x_r[W-2:0], dge};
      end
    end
  end

  assign done = done_r;
  assign quot = x_r;
  assign acc  = acc_r[W-1:0];

endmodule

// ===== src/pm0_instruction_execute.sv =====
// Top level: PM/0 register stack machine that executes one instruction per transaction.
//
// The in_ch channel carries one instruction (op, reg_sel, field_l, field_m, in_value)
// per transaction; out_ch returns one result per instruction, in order: next_pc,
// base_ptr, stack_ptr, out_value/out_valid for the output instruction, halted and fault.
// Instructions are taken one at a time. Each runs the register reads S_RA, S_RB and
// S_RR, S_EXEC, its opcode's extra states and S_FIN, which registers the result. JMP,
// INC and a taken JPC add a reduction; LOD and STO add a link read and reduction per
// static-link level and the frame access (LOD also a read when in range); CAL adds frame
// writes around that walk; RTN reads and reduces the saved base and return address.
// MUL, and DIV and MOD with a nonzero divisor, wait for the one-bit-per-cycle muldiv unit.
// After halt, an instruction goes straight to S_FIN. STACK_DEPTH and CODE_DEPTH must be
// powers of two, which the block does not check, so pointer words reduce by masking.
// After reset a clearing pass writes zero to every stack entry, during which no
// instruction is accepted. A result waits in an output register while the receiver
// stalls; the next instruction can be accepted and executed meanwhile, and it
// completes only once that register is free.
module pm0_instruction_execute #(
  parameter int STACK_DEPTH = 64,
  parameter int CODE_DEPTH  = 256,
  parameter int NUM_REGS    = 8,
  parameter int WORD_WIDTH  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  pm0_in_if.sink   in_ch,
  pm0_out_if.source out_ch
);
  import pm0_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int CA = $clog2(CODE_DEPTH);
  localparam int RA = $clog2(NUM_REGS);
  localparam int SW = W + 2;

  // Sequencer states.
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_RA      = 5'd2;
  localparam logic [4:0] S_RB      = 5'd3;
  localparam logic [4:0] S_RR      = 5'd4;
  localparam logic [4:0] S_EXEC    = 5'd5;
  localparam logic [4:0] S_WALK    = 5'd6;
  localparam logic [4:0] S_WALK_RD = 5'd7;
  localparam logic [4:0] S_RED     = 5'd8;
  localparam logic [4:0] S_LOD_RD  = 5'd10;
  localparam logic [4:0] S_RTN_BP  = 5'd11;
  localparam logic [4:0] S_RTN_BPD = 5'd12;
  localparam logic [4:0] S_RTN_PC  = 5'd13;
  localparam logic [4:0] S_RTN_PCD = 5'd14;
  localparam logic [4:0] S_CAL_W   = 5'd15;
  localparam logic [4:0] S_AR_WT   = 5'd16;
  localparam logic [4:0] S_FIN     = 5'd17;

  // What a finished reduction feeds.
  localparam logic [1:0] K_WALK = 2'd0;
  localparam logic [1:0] K_BP   = 2'd1;
  localparam logic [1:0] K_PC   = 2'd2;
  localparam logic [1:0] K_INC  = 2'd3;

  localparam logic [SA:0]   STK_E = (SA+1)'(STACK_DEPTH);

  logic [4:0]    state_r;
  logic [SA:0]   clr_cnt_r;
  logic [CA-1:0] pc_r;
  logic [SA-1:0] bp_r;
  logic [SA-1:0] sp_r;
  logic          halt_r;
  logic [1:0]    fault_r;
  logic [W-1:0]  outv_r;
  logic          outok_r;
  logic [W-1:0]  regs_r [NUM_REGS];

  logic [4:0]    op_r;
  logic [RA-1:0] r_r;
  logic [RA-1:0] l_r;
  logic [RA-1:0] mr_r;
  logic [2:0]    lvl_r;
  logic [W-1:0]  mw_r;
  logic [W-1:0]  inv_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  rv_r;
  logic [SA-1:0] bcur_r;
  logic [W-1:0]  red_w_r;
  logic [1:0]    red_k_r;
  logic [1:0]    calk_r;

  logic          o_vld_r;
  logic [7:0]    o_pc_r;
  logic [5:0]    o_bp_r;
  logic [5:0]    o_sp_r;
  logic [31:0]   o_val_r;
  logic          o_ok_r;
  logic          o_halt_r;
  logic [1:0]    o_fault_r;

  logic          ram_we;
  logic [SA-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [SA-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  md_ctl_t       md_ctl;
  logic [W-1:0]  md_a;
  logic [W-1:0]  md_b;
  logic          md_done;
  logic [W-1:0]  md_quot;
  logic [W-1:0]  md_acc;

  logic          in_fire;
  logic          out_free;
  logic [SA:0]   lnk_addr;
  logic          lnk_ok;
  logic signed [SW-1:0] off_sum;
  logic          off_ok;
  logic [SA:0]   rtn_addr;
  logic          rtn_ok;
  logic [SA:0]   cal_addr;
  logic          cal_ok;
  logic [W-1:0]  cal_data;
  logic [W-1:0]  red_res;
  logic [SA:0]   inc_sum;
  logic          a_neg;
  logic          b_neg;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;
  logic [W-1:0]  odd_res;
  logic [SA:0]   sp_inc;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !o_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Address arithmetic for links, LOD/STO offsets, RTN frame reads and CAL writes.
  assign lnk_addr = {1'b0, bcur_r} + 1'b1;
  assign lnk_ok   = (lnk_addr < STK_E);
  assign off_sum  = $signed({{(SW-SA){1'b0}}, bcur_r}) + SW'($signed(mw_r));
  assign off_ok   = !off_sum[SW-1] && ($unsigned(off_sum) < SW'(STACK_DEPTH));
  assign rtn_addr = {1'b0, sp_r} + ((state_r == S_RTN_BP) ? (SA+1)'(3) : (SA+1)'(4));
  assign rtn_ok   = (rtn_addr < STK_E);
  assign cal_addr = {1'b0, sp_r} + (SA+1)'(calk_r) + 1'b1;
  assign cal_ok   = (cal_addr < STK_E);
  assign sp_inc   = {1'b0, sp_r} + 1'b1;

  // Frame word stored by each CAL write.
  always_comb begin
    unique case (calk_r)
      2'd0:    cal_data = '0;
      2'd1:    cal_data = W'(bcur_r);
      2'd2:    cal_data = W'(bp_r);
      default: cal_data = W'(pc_r);
    endcase
  end

  // A signed word reduced modulo a power-of-two depth is its low bits.
  assign red_res = (red_k_r == K_PC) ? W'(red_w_r[CA-1:0]) : W'(red_w_r[SA-1:0]);
  assign inc_sum = {1'b0, sp_r} + {1'b0, red_res[SA-1:0]};

  // Operand signs and magnitudes for division.
  assign a_neg = a_r[W-1];
  assign b_neg = b_r[W-1];
  assign a_mag = a_neg ? (W'(0) - a_r) : a_r;
  assign b_mag = b_neg ? (W'(0) - b_r) : b_r;
  assign odd_res = (rv_r[W-1] && rv_r[0]) ? '1 : W'(rv_r[0]);

  // Start requests for the multiply/divide unit.
  always_comb begin
    md_ctl = '0;
    md_a   = a_mag;
    md_b   = b_mag;
    if (state_r == S_EXEC) begin
      if (op_r == OP_MUL) begin
        md_ctl.start = 1'b1;
        md_ctl.mul   = 1'b1;
        md_a = a_r;
        md_b = b_r;
      end else if ((op_r == OP_DIV || op_r == OP_MOD) && b_r != '0) begin
        md_ctl.start = 1'b1;
      end
    end
  end

  // Stack memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r[SA-1:0];
      end
      S_WALK: begin
        if (lvl_r != 3'd0) begin
          ram_raddr = lnk_addr[SA-1:0];
        end else begin
          ram_raddr = off_sum[SA-1:0];
          ram_waddr = off_sum[SA-1:0];
          ram_wdata = rv_r;
          ram_we    = (op_r == OP_STO) && off_ok;
        end
      end
      S_RTN_BP, S_RTN_PC: begin
        ram_raddr = rtn_addr[SA-1:0];
      end
      S_CAL_W: begin
        ram_we    = cal_ok;
        ram_waddr = cal_addr[SA-1:0];
        ram_wdata = cal_data;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      pc_r      <= '0;
      bp_r      <= SA'(1 % STACK_DEPTH);
      sp_r      <= '0;
      halt_r    <= 1'b0;
      fault_r   <= FLT_NONE;
      outok_r   <= 1'b0;
      o_vld_r   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (o_vld_r && out_ch.ready && (state_r != S_FIN)) begin
        o_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == STK_E - 1'b1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_ch.op;
            r_r     <= RA'(in_ch.reg_sel);
            l_r     <= RA'(in_ch.field_l);
            lvl_r   <= in_ch.field_l;
            mr_r    <= in_ch.field_m[RA-1:0];
            mw_r    <= W'(in_ch.field_m);
            inv_r   <= W'(in_ch.in_value);
            fault_r <= FLT_NONE;
            outok_r <= 1'b0;
            outv_r  <= '0;
            if (halt_r) begin
              state_r <= S_FIN;
            end else begin
              pc_r    <= (pc_r == CA'(CODE_DEPTH - 1)) ? '0 : pc_r + 1'b1;
              state_r <= S_RA;
            end
          end
        end
        S_RA: begin
          a_r     <= regs_r[l_r];
          state_r <= S_RB;
        end
        S_RB: begin
          b_r     <= regs_r[mr_r];
          state_r <= S_RR;
        end
        S_RR: begin
          rv_r    <= regs_r[r_r];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_FIN;
          bcur_r  <= bp_r;
          red_w_r <= mw_r;
          red_k_r <= K_PC;
          calk_r  <= 2'd0;
          unique case (op_r)
            OP_LIT: regs_r[r_r] <= mw_r;
            OP_RTN: begin
              sp_r    <= (bp_r == '0) ? SA'(STACK_DEPTH - 1) : bp_r - 1'b1;
              state_r <= S_RTN_BP;
            end
            OP_LOD, OP_STO: state_r <= S_WALK;
            // CAL clears its first frame slot before the static-link walk.
            OP_CAL: state_r <= S_CAL_W;
            OP_INC: begin
              red_k_r <= K_INC;
              state_r <= S_RED;
            end
            OP_JMP: state_r <= S_RED;
            OP_JPC: if (rv_r == '0) state_r <= S_RED;
            OP_OUT: begin
              outv_r  <= rv_r;
              outok_r <= 1'b1;
            end
            OP_IN:  regs_r[r_r] <= inv_r;
            OP_HLT: halt_r <= 1'b1;
            OP_NEG: regs_r[r_r] <= W'(0) - a_r;
            OP_ADD: regs_r[r_r] <= a_r + b_r;
            OP_SUB: regs_r[r_r] <= a_r - b_r;
            OP_MUL: state_r <= S_AR_WT;
            OP_DIV, OP_MOD: begin
              if (b_r == '0) begin
                regs_r[r_r] <= '0;
                fault_r     <= FLT_DIV0;
              end else begin
                state_r <= S_AR_WT;
              end
            end
            OP_ODD: regs_r[r_r] <= odd_res;
            OP_EQL: regs_r[r_r] <= W'(a_r == b_r);
            OP_NEQ: regs_r[r_r] <= W'(a_r != b_r);
            OP_LSS: regs_r[r_r] <= W'($signed(a_r) < $signed(b_r));
            OP_LEQ: regs_r[r_r] <= W'(!($signed(b_r) < $signed(a_r)));
            OP_GTR: regs_r[r_r] <= W'($signed(b_r) < $signed(a_r));
            OP_GEQ: regs_r[r_r] <= W'(!($signed(a_r) < $signed(b_r)));
            default: state_r <= S_FIN;
          endcase
        end
        S_WALK: begin
          if (lvl_r != 3'd0) begin
            red_k_r <= K_WALK;
            if (lnk_ok) begin
              state_r <= S_WALK_RD;
            end else begin
              fault_r <= FLT_STACK;
              red_w_r <= '0;
              state_r <= S_RED;
            end
          end else if (op_r == OP_CAL) begin
            state_r <= S_CAL_W;
          end else begin
            state_r <= S_FIN;
            if (!off_ok) begin
              fault_r <= FLT_STACK;
              if (op_r == OP_LOD) regs_r[r_r] <= '0;
            end else if (op_r == OP_LOD) begin
              state_r <= S_LOD_RD;
            end
          end
        end
        S_WALK_RD: begin
          red_w_r <= ram_rdata;
          state_r <= S_RED;
        end
        S_RED: begin
          unique case (red_k_r)
            K_WALK: begin
              bcur_r  <= red_res[SA-1:0];
              lvl_r   <= lvl_r - 1'b1;
              state_r <= S_WALK;
            end
            K_BP: begin
              bp_r    <= red_res[SA-1:0];
              state_r <= S_RTN_PC;
            end
            K_PC: begin
              pc_r    <= red_res[CA-1:0];
              state_r <= S_FIN;
            end
            default: begin
              sp_r    <= (inc_sum >= STK_E) ? SA'(inc_sum - STK_E) : inc_sum[SA-1:0];
              state_r <= S_FIN;
            end
          endcase
        end
        S_LOD_RD: begin
          regs_r[r_r] <= ram_rdata;
          state_r     <= S_FIN;
        end
        S_RTN_BP, S_RTN_PC: begin
          red_k_r <= (state_r == S_RTN_BP) ? K_BP : K_PC;
          if (rtn_ok) begin
            state_r <= (state_r == S_RTN_BP) ? S_RTN_BPD : S_RTN_PCD;
          end else begin
            fault_r <= FLT_STACK;
            red_w_r <= '0;
            state_r <= S_RED;
          end
        end
        S_RTN_BPD, S_RTN_PCD: begin
          red_w_r <= ram_rdata;
          state_r <= S_RED;
        end
        S_CAL_W: begin
          if (!cal_ok) fault_r <= FLT_STACK;
          calk_r <= calk_r + 1'b1;
          if (calk_r == 2'd0) begin
            state_r <= S_WALK;
          end else if (calk_r == 2'd3) begin
            bp_r    <= (sp_inc == STK_E) ? '0 : sp_inc[SA-1:0];
            red_w_r <= mw_r;
            red_k_r <= K_PC;
            state_r <= S_RED;
          end
        end
        S_AR_WT: begin
          if (md_done) begin
            state_r <= S_FIN;
            unique case (op_r)
              OP_MUL:  regs_r[r_r] <= md_acc;
              OP_DIV:  regs_r[r_r] <= (a_neg != b_neg) ? (W'(0) - md_quot) : md_quot;
              default: regs_r[r_r] <= a_neg ? (W'(0) - md_acc) : md_acc;
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            o_vld_r   <= 1'b1;
            o_pc_r    <= 8'(pc_r);
            o_bp_r    <= 6'(bp_r);
            o_sp_r    <= 6'(sp_r);
            o_val_r   <= outok_r ? 32'($signed(outv_r)) : 32'd0;
            o_ok_r    <= outok_r;
            o_halt_r  <= halt_r;
            o_fault_r <= fault_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result channel.
  assign out_ch.valid     = o_vld_r;
  assign out_ch.next_pc   = o_pc_r;
  assign out_ch.base_ptr  = o_bp_r;
  assign out_ch.stack_ptr = o_sp_r;
  assign out_ch.out_value = o_val_r;
  assign out_ch.out_valid = o_ok_r;
  assign out_ch.halted    = o_halt_r;
  assign out_ch.fault     = o_fault_r;

  pm0_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (SA),
    .W     (W)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pm0_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (md_ctl),
    .opa   (md_a),
    .opb   (md_b),
    .done  (md_done),
    .quot  (md_quot),
    .acc   (md_acc)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the PM/0 instruction execute block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pm0_pkg::*;

  localparam int NUM_RANDOM = 1750;
  localparam int STK_N = 64;

  typedef struct packed {
    logic [4:0]         op;
    logic [2:0]         reg_sel;
    logic [2:0]         field_l;
    logic signed [31:0] field_m;
    logic signed [31:0] in_value;
  } instr_t;

  typedef struct packed {
    logic [7:0]         next_pc;
    logic [5:0]         base_ptr;
    logic [5:0]         stack_ptr;
    logic signed [31:0] out_value;
    logic               out_valid;
    logic               halted;
    logic [1:0]         fault;
  } exec_result_t;

  typedef struct {
    instr_t       instr;
    bit           typed;
    exec_result_t want;
  } program_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pm0_in_if  in_ch ();
  pm0_out_if out_ch ();

  pm0_instruction_execute dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Machine state mirrored by the predictor.
  logic signed [31:0] regs [8];
  logic signed [31:0] stk [STK_N];
  logic [7:0]         pc;
  logic [5:0]         bp;
  logic [5:0]         sp;
  logic               mach_halted;
  logic [1:0]         step_flt;

  exec_result_t   pending_results [$];
  program_row_t   program_rows [$];
  int unsigned    mismatches = 0;
  int unsigned    instr_count = 0;
  int unsigned    result_count = 0;
  int unsigned    output_count = 0;
  int unsigned    fault_count = 0;
  bit             idling = 1'b1;

  // Stack access with range checking; out-of-range reads give zero.
  function automatic logic signed [31:0] stack_fetch(input int addr);
    if (addr < 0 || addr >= STK_N) begin
      step_flt = FLT_STACK;
      return '0;
    end
    return stk[addr];
  endfunction

  function automatic void stack_store(input int addr, input logic signed [31:0] val);
    if (addr < 0 || addr >= STK_N) begin
      step_flt = FLT_STACK;
      return;
    end
    stk[addr] = val;
  endfunction

  // Follow static links the given number of levels down from a base.
  function automatic int follow_links(input int levels, input int base);
    logic signed [31:0] w;
    for (int i = 0; i < levels; i++) begin
      w = stack_fetch(base + 1);
      base = int'(w[5:0]);
    end
    return base;
  endfunction

  // Base plus signed offset, or an out-of-range address.
  function automatic int frame_addr(input int base, input logic signed [31:0] m);
    longint s;
    s = longint'(base) + longint'(m);
    if (s < 0 || s >= STK_N) return STK_N;
    return int'(s);
  endfunction

  // Execute one instruction on the mirrored state and return its result.
  function automatic exec_result_t execute_instr(input instr_t it);
    exec_result_t       res;
    logic signed [31:0] a, b, w;
    int                 t;
    res = '0;
    step_flt = FLT_NONE;
    if (!mach_halted) begin
      a = regs[it.field_l];
      b = regs[it.field_m[2:0]];
      pc = pc + 8'd1;
      case (it.op)
        OP_LIT: regs[it.reg_sel] = it.field_m;
        OP_RTN: begin
          sp = bp - 6'd1;
          w = stack_fetch(int'(sp) + 3);
          bp = w[5:0];
          w = stack_fetch(int'(sp) + 4);
          pc = w[7:0];
        end
        OP_LOD: begin
          t = frame_addr(follow_links(int'(it.field_l), int'(bp)), it.field_m);
          regs[it.reg_sel] = stack_fetch(t);
        end
        OP_STO: begin
          t = frame_addr(follow_links(int'(it.field_l), int'(bp)), it.field_m);
          stack_store(t, regs[it.reg_sel]);
        end
        OP_CAL: begin
          // The first link slot is written before the walk reads the stack.
          stack_store(int'(sp) + 1, '0);
          t = follow_links(int'(it.field_l), int'(bp));
          stack_store(int'(sp) + 2, t);
          stack_store(int'(sp) + 3, 32'(bp));
          stack_store(int'(sp) + 4, 32'(pc));
          bp = sp + 6'd1;
          pc = it.field_m[7:0];
        end
        OP_INC: sp = sp + it.field_m[5:0];
        OP_JMP: pc = it.field_m[7:0];
        OP_JPC: if (regs[it.reg_sel] == 0) pc = it.field_m[7:0];
        OP_OUT: begin
          res.out_value = regs[it.reg_sel];
          res.out_valid = 1'b1;
        end
        OP_IN:  regs[it.reg_sel] = it.in_value;
        OP_HLT: mach_halted = 1'b1;
        OP_NEG: regs[it.reg_sel] = -a;
        OP_ADD: regs[it.reg_sel] = a + b;
        OP_SUB: regs[it.reg_sel] = a - b;
        OP_MUL: regs[it.reg_sel] = a * b;
        OP_DIV, OP_MOD: begin
          if (b == 0) begin
            step_flt = FLT_DIV0;
            regs[it.reg_sel] = '0;
          end else if (it.op == OP_DIV) begin
            regs[it.reg_sel] = 32'(longint'(a) / longint'(b));
          end else begin
            regs[it.reg_sel] = 32'(longint'(a) % longint'(b));
          end
        end
        OP_ODD: regs[it.reg_sel] = regs[it.reg_sel] % 32'sd2;
        OP_EQL: regs[it.reg_sel] = {31'd0, a == b};
        OP_NEQ: regs[it.reg_sel] = {31'd0, a != b};
        OP_LSS: regs[it.reg_sel] = {31'd0, a < b};
        OP_LEQ: regs[it.reg_sel] = {31'd0, a <= b};
        OP_GTR: regs[it.reg_sel] = {31'd0, a > b};
        OP_GEQ: regs[it.reg_sel] = {31'd0, a >= b};
        default: ;
      endcase
    end
    res.next_pc   = pc;
    res.base_ptr  = bp;
    res.stack_ptr = sp;
    res.halted    = mach_halted;
    res.fault     = step_flt;
    return res;
  endfunction

  function automatic instr_t make_instr(input logic [4:0] op, input int r, input int l,
                                        input logic signed [31:0] m,
                                        input logic signed [31:0] iv = 0);
    instr_t it;
    it.op = op;
    it.reg_sel = r[2:0];
    it.field_l = l[2:0];
    it.field_m = m;
    it.in_value = iv;
    return it;
  endfunction

  function automatic void add_row(input instr_t it, input bit typed = 1'b0,
                                  input exec_result_t want = '0);
    program_row_t row;
    row.instr = it;
    row.typed = typed;
    row.want = want;
    program_rows.push_back(row);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 16)) - 4;
      5, 6, 7:       return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Random instruction weighted toward frame and stack traffic.
  function automatic instr_t rand_instr();
    instr_t     it;
    int unsigned pick;
    logic [4:0] frame_ops [6] = '{OP_LIT, OP_LOD, OP_STO, OP_CAL, OP_RTN, OP_INC};
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      pick = $urandom_range(0, 7);
      it.op = (pick == 0) ? 5'd0 : 5'(24 + pick);
    end else if (pick < 45) begin
      it.op = frame_ops[$urandom_range(0, 5)];
    end else begin
      it.op = 5'($urandom_range(1, 24));
      if (it.op == OP_HLT) it.op = OP_IN;
    end
    it.reg_sel = 3'($urandom_range(0, 7));
    it.field_l = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 2))
                                            : 3'($urandom_range(0, 7));
    it.field_m = rand_word();
    it.in_value = ($urandom_range(0, 3) == 0) ? rand_word() : $signed($urandom);
    return it;
  endfunction

  // Send one instruction, after a random gap while idling is set, and record its expected result.
  task automatic issue_instr(input instr_t it, input bit typed, input exec_result_t want);
    int unsigned  gap;
    exec_result_t res;
    gap = idling ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= it.op;
    in_ch.reg_sel  <= it.reg_sel;
    in_ch.field_l  <= it.field_l;
    in_ch.field_m  <= it.field_m;
    in_ch.in_value <= it.in_value;
    do @(posedge clk); while (!in_ch.ready);
    res = execute_instr(it);
    pending_results.push_back(typed ? want : res);
    instr_count++;
  endtask

  // Result side: random stalls while idling is set, then compare each transaction with the oldest expectation.
  initial begin
    exec_result_t got, exp_res;
    int unsigned  stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idling ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.next_pc, out_ch.base_ptr, out_ch.stack_ptr, out_ch.out_value,
              out_ch.out_valid, out_ch.halted, out_ch.fault};
      result_count++;
      if (got.out_valid) output_count++;
      if (got.fault != FLT_NONE) fault_count++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction %p", got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", result_count);
            $display("  expected pc=%0d bp=%0d sp=%0d val=%0d ov=%0b h=%0b flt=%0d",
                     exp_res.next_pc, exp_res.base_ptr, exp_res.stack_ptr,
                     exp_res.out_value, exp_res.out_valid, exp_res.halted, exp_res.fault);
            $display("  actual   pc=%0d bp=%0d sp=%0d val=%0d ov=%0b h=%0b flt=%0d",
                     got.next_pc, got.base_ptr, got.stack_ptr, got.out_value,
                     got.out_valid, got.halted, got.fault);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed program, random program, halt, drain.
  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= '0;
    in_ch.reg_sel  <= '0;
    in_ch.field_l  <= '0;
    in_ch.field_m  <= '0;
    in_ch.in_value <= '0;
    foreach (regs[i]) regs[i] = '0;
    foreach (stk[i]) stk[i] = '0;
    pc = '0;
    bp = 6'd1;
    sp = '0;
    mach_halted = 1'b0;

    // Directed rows: extremes, faults, frame linkage, every opcode but HLT and two invalid opcodes.
    add_row(make_instr(OP_LIT, 0, 0, 32'sh7fff_ffff), 1, '{8'd1, 6'd1, 6'd0, 0, 0, 0, FLT_NONE});
    add_row(make_instr(OP_LIT, 1, 7, 32'sh8000_0000), 1, '{8'd2, 6'd1, 6'd0, 0, 0, 0, FLT_NONE});
    add_row(make_instr(OP_OUT, 1, 0, 0), 1,
            '{8'd3, 6'd1, 6'd0, 32'sh8000_0000, 1, 0, FLT_NONE});
    add_row(make_instr(OP_DIV, 2, 1, 3), 1, '{8'd4, 6'd1, 6'd0, 0, 0, 0, FLT_DIV0});
    add_row(make_instr(OP_MOD, 2, 0, 3), 1, '{8'd5, 6'd1, 6'd0, 0, 0, 0, FLT_DIV0});
    add_row(make_instr(OP_LIT, 3, 0, -1));
    add_row(make_instr(OP_DIV, 4, 1, 32'sh7fff_fffb));
    add_row(make_instr(OP_MOD, 5, 1, 3));
    add_row(make_instr(OP_OUT, 5, 0, 0), 1, '{8'd9, 6'd1, 6'd0, 0, 1, 0, FLT_NONE});
    add_row(make_instr(OP_LOD, 6, 0, -2), 1, '{8'd10, 6'd1, 6'd0, 0, 0, 0, FLT_STACK});
    add_row(make_instr(OP_STO, 0, 0, 63), 1, '{8'd11, 6'd1, 6'd0, 0, 0, 0, FLT_STACK});
    add_row(make_instr(OP_LOD, 6, 7, 0));
    add_row(make_instr(OP_INC, 0, 0, 5), 1, '{8'd13, 6'd1, 6'd5, 0, 0, 0, FLT_NONE});
    add_row(make_instr(OP_CAL, 0, 1, 200));
    add_row(make_instr(OP_INC, 0, 0, 4));
    add_row(make_instr(OP_STO, 0, 0, 3));
    add_row(make_instr(OP_LOD, 7, 1, 4));
    add_row(make_instr(OP_RTN, 0, 0, 0));
    add_row(make_instr(OP_ODD, 3, 0, 0));
    add_row(make_instr(OP_NEG, 6, 1, 0));
    add_row(make_instr(OP_MUL, 6, 0, 32'sd11));
    add_row(make_instr(OP_ADD, 2, 0, 32'sd1));
    add_row(make_instr(OP_SUB, 2, 1, 32'sd0));
    add_row(make_instr(OP_EQL, 7, 0, 0));
    add_row(make_instr(OP_NEQ, 7, 1, 0));
    add_row(make_instr(OP_LSS, 7, 1, 0));
    add_row(make_instr(OP_LEQ, 7, 0, 0));
    add_row(make_instr(OP_GTR, 7, 0, 1));
    add_row(make_instr(OP_GEQ, 7, 1, 0));
    add_row(make_instr(OP_JPC, 2, 0, 32'sh8000_0010));
    add_row(make_instr(OP_JMP, 0, 0, -1), 1, '{8'd255, 6'd1, 6'd5, 0, 0, 0, FLT_NONE});
    add_row(make_instr(OP_IN, 4, 0, 0, 32'sh8000_0000));
    add_row(make_instr(5'd0, 0, 0, 0));
    add_row(make_instr(5'd31, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (program_rows[i])
      issue_instr(program_rows[i].instr, program_rows[i].typed, program_rows[i].want);

    // Random program, with idling switched off for some stretches.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) idling = ($urandom_range(0, 3) != 0);
      issue_instr(rand_instr(), 1'b0, '0);
    end

    // Halt, then instructions that must leave the machine untouched.
    idling = 1'b1;
    issue_instr(make_instr(OP_HLT, 0, 0, 0), 1'b0, '0);
    issue_instr(make_instr(OP_OUT, 0, 0, 0), 1'b0, '0);
    issue_instr(make_instr(OP_JMP, 0, 0, 7), 1'b0, '0);
    issue_instr(make_instr(OP_DIV, 1, 1, 2), 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d instructions and checked %0d results.", instr_count, result_count);
    $display("Results carried %0d outputs and %0d faults.", output_count, fault_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
